// ===== src/salsl_pkg.sv =====
`default_nettype none

package salsl_pkg;

    localparam int STATE_W    = 32;
    localparam int STATE_FRAC = 28;
    localparam int MW         = 34;
    localparam int DW         = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int RST_THR_W  = 23;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_THR    = 2'd2;

    localparam longint RST_FIRST_COEF  = 6408326;
    localparam longint RST_SMOOTH_COEF = 49493;
    localparam longint RST_SLEW_THR    = 3204163;

    localparam logic [1:0] FIRST_STAGE = 2'd0;
    localparam logic [1:0] LAST_STAGE  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_MUL,
        OP_ACC,
        OP_HP,
        OP_CLAMP,
        OP_CONV,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic       capture;
        op_t        op;
        logic       ch;
        logic [1:0] stage;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/salsl_ctrl.sv =====
`default_nettype none

module salsl_ctrl
    import salsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_DIFF  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_ACC   = 9'b000010000,
        ST_HP    = 9'b000100000,
        ST_CLAMP = 9'b001000000,
        ST_CONV  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       ch_reg;
    logic       ch_next;
    logic [1:0] stage_reg;
    logic [1:0] stage_next;

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        stage_next  = stage_reg;
        cmd.op      = OP_NONE;
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.ch      = ch_reg;
        cmd.stage   = stage_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                    ch_next    = 1'b0;
                end
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                stage_next = FIRST_STAGE;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                if (stage_reg == LAST_STAGE)
                begin
                    state_next = ST_HP;
                end
                else
                begin
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_DIFF;
                end
            end
            ST_HP:
            begin
                cmd.op     = OP_HP;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.op = OP_CONV;
                if (ch_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ch_next    = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (!status.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
            stage_reg <= FIRST_STAGE;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/salsl_dpath.sv =====
`default_nettype none

module salsl_dpath
    import salsl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24,
    parameter int CFG_W       = 25,
    parameter int IO_W        = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [IO_W-1:0]      s_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [IO_W-1:0]      m_tdata
);

    localparam int CW    = COEF_BITS + 1;
    localparam int PW    = MW + CW + 1;
    localparam int THR_W = (SAMPLE_BITS - 1 > RST_THR_W) ? SAMPLE_BITS - 1 : RST_THR_W;
    localparam int UP    = (STATE_FRAC >= SAMPLE_BITS - 1) ? STATE_FRAC - (SAMPLE_BITS - 1) : 0;
    localparam int DN    = (STATE_FRAC < SAMPLE_BITS - 1) ? (SAMPLE_BITS - 1) - STATE_FRAC : 0;

    localparam logic [CW-1:0] COEF_ONE = {1'b1, {COEF_BITS{1'b0}}};
    localparam logic [CW-1:0] RST_C1 =
        (RST_FIRST_COEF > (longint'(1) << COEF_BITS)) ? COEF_ONE : CW'(RST_FIRST_COEF);
    localparam logic [CW-1:0] RST_C2 =
        (RST_SMOOTH_COEF > (longint'(1) << COEF_BITS)) ? COEF_ONE : CW'(RST_SMOOTH_COEF);
    localparam logic [THR_W-1:0] RST_THR = THR_W'(RST_SLEW_THR);

    localparam logic signed [PW-1:0] HALF = PW'(longint'(1) << (COEF_BITS - 1));
    localparam logic signed [DW-1:0] RND =
        DW'((UP > 0) ? (longint'(1) << ((UP > 0) ? UP - 1 : 0)) : longint'(0));
    localparam logic signed [DW-1:0] SMAX = DW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [DW-1:0] SMIN = -SMAX - DW'(1);
    localparam logic signed [DW-1:0] I32MAX = DW'(longint'(2147483647));
    localparam logic signed [DW-1:0] I32MIN = -I32MAX - DW'(1);

    logic [CW-1:0]    c1_reg;
    logic [CW-1:0]    c2_reg;
    logic [THR_W-1:0] thr_reg;

    logic signed [STATE_W-1:0] bank_reg [2][3][2];
    logic signed [STATE_W-1:0] prev_reg [2];
    logic                      bank_sel_reg;
    logic                      out_valid_reg;
    logic [IO_W-1:0]           out_data_reg;

    logic signed [SAMPLE_BITS-1:0] samp_reg [2];
    logic signed [SAMPLE_BITS-1:0] res_reg [2];
    logic signed [DW-1:0]          dry_reg;
    logic signed [STATE_W-1:0]     acc_reg;
    logic signed [STATE_W-1:0]     a_reg;
    logic signed [STATE_W-1:0]     y_reg;
    logic signed [MW-1:0]          d_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [DW-1:0]          hp_reg;
    logic signed [DW-1:0]          hi_reg;
    logic signed [DW-1:0]          lo_reg;
    logic signed [STATE_W-1:0]     hpc_reg;

    logic                          sel;
    logic                          emit_fire;
    logic [CW-1:0]                 c_wr;
    logic signed [SAMPLE_BITS-1:0] samp;
    logic signed [DW-1:0]          dry_w;
    logic signed [DW-1:0]          x_full;
    logic signed [STATE_W-1:0]     y_rd;
    logic signed [MW-1:0]          d_w;
    logic [CW-1:0]                 c_sel;
    logic signed [PW-1:0]          prod_w;
    logic signed [PW-1:0]          r_full;
    logic signed [MW-1:0]          acc_sum;
    logic signed [STATE_W-1:0]     new_val;
    logic signed [DW-1:0]          thr_int;
    logic signed [DW-1:0]          clamp_w;
    logic signed [STATE_W-1:0]     sat32_w;
    logic signed [DW-1:0]          conv_full;
    logic signed [DW-1:0]          conv_sat;

    assign sel       = ~bank_sel_reg;
    assign emit_fire = (cmd.op == OP_EMIT) && !status.out_stall;

    assign status.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;

    // coefficients above one are held at exactly one
    assign c_wr = (cfg_data[CW-1:0] > COEF_ONE) ? COEF_ONE : cfg_data[CW-1:0];

    always_comb
    begin
        samp     = cmd.ch ? samp_reg[1] : samp_reg[0];
        dry_w    = (DW'(samp) <<< UP) >>> DN;
        x_full   = (dry_w + DW'(prev_reg[cmd.ch])) >>> 1;
        y_rd     = bank_reg[cmd.ch][cmd.stage][sel];
        d_w      = MW'(acc_reg) - MW'(y_rd);
        c_sel    = (cmd.stage == FIRST_STAGE) ? c1_reg : c2_reg;
        prod_w   = PW'(d_reg) * PW'($signed({1'b0, c_sel}));
        r_full   = (prod_reg + HALF) >>> COEF_BITS;
        acc_sum  = MW'(y_reg) + $signed(r_full[MW-1:0]);
        new_val  = $signed(acc_sum[STATE_W-1:0]);
        thr_int  = (DW'($signed({1'b0, thr_reg})) <<< UP) >>> DN;

        if (hp_reg > hi_reg)
        begin
            clamp_w = hi_reg;
        end
        else if (hp_reg < lo_reg)
        begin
            clamp_w = lo_reg;
        end
        else
        begin
            clamp_w = hp_reg;
        end

        if (clamp_w > I32MAX)
        begin
            sat32_w = $signed(I32MAX[STATE_W-1:0]);
        end
        else if (clamp_w < I32MIN)
        begin
            sat32_w = $signed(I32MIN[STATE_W-1:0]);
        end
        else
        begin
            sat32_w = $signed(clamp_w[STATE_W-1:0]);
        end

        // round half up, back to sample format
        conv_full = ((DW'(hpc_reg) + RND) >>> UP) <<< DN;
        if (conv_full > SMAX)
        begin
            conv_sat = SMAX;
        end
        else if (conv_full < SMIN)
        begin
            conv_sat = SMIN;
        end
        else
        begin
            conv_sat = conv_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg        <= RST_C1;
            c2_reg        <= RST_C2;
            thr_reg       <= RST_THR;
            bank_sel_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prev_reg[i] <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        bank_reg[i][j][k] <= '0;
                    end
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FIRST_COEF:  c1_reg <= c_wr;
                    REG_SMOOTH_COEF: c2_reg <= c_wr;
                    REG_SLEW_THR:    thr_reg <= THR_W'(cfg_data[SAMPLE_BITS-2:0]);
                    default:         ;
                endcase
            end
            if (cmd.op == OP_ACC)
            begin
                bank_reg[cmd.ch][cmd.stage][sel] <= new_val;
            end
            if (cmd.op == OP_CLAMP)
            begin
                prev_reg[cmd.ch] <= sat32_w;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                bank_sel_reg  <= ~bank_sel_reg;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            samp_reg[0] <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            samp_reg[1] <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        case (cmd.op)
            OP_LOAD:
            begin
                dry_reg <= dry_w;
                acc_reg <= $signed(x_full[STATE_W-1:0]);
            end
            OP_DIFF:
            begin
                y_reg <= y_rd;
                d_reg <= d_w;
            end
            OP_MUL:
            begin
                prod_reg <= prod_w;
            end
            OP_ACC:
            begin
                acc_reg <= new_val;
                if (cmd.stage == FIRST_STAGE)
                begin
                    a_reg <= new_val;
                end
            end
            OP_HP:
            begin
                hp_reg <= dry_reg - DW'(acc_reg);
                hi_reg <= DW'(a_reg) + thr_int;
                lo_reg <= DW'(a_reg) - thr_int;
            end
            OP_CLAMP:
            begin
                hpc_reg <= sat32_w;
            end
            OP_CONV:
            begin
                res_reg[cmd.ch] <= $signed(conv_sat[SAMPLE_BITS-1:0]);
            end
            default:
            begin
            end
        endcase
        if (emit_fire)
        begin
            out_data_reg <= IO_W'({res_reg[1], res_reg[0]});
        end
    end

endmodule

`default_nettype wire

// ===== src/stereo_alternating_lowpass_slew_limiter_top.sv =====
// channel   dir  signals                               contents
// s_axis    in   s_tvalid s_tready s_tdata             one stereo sample pair
// m_axis    out  m_tvalid m_tready m_tdata             one processed stereo pair
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data  coefficient and threshold writes
//
// each pair runs through an accept step, then per channel (load, three filter stages of
// diff / multiply / accumulate on one shared multiplier, highpass, clamp, convert) and a
// final step to load the output register
// reset clears all filter banks and previous outputs at once and selects the first bank
// a new pair is taken while the last result still waits; a stalled output holds the
// block in its final cycle until the transaction completes
// cfg_ready is always high
`default_nettype none

module stereo_alternating_lowpass_slew_limiter_top
    import salsl_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    parameter  int COEF_BITS   = 24,
    localparam int CFG_W = (COEF_BITS + 1 > SAMPLE_BITS - 1) ? COEF_BITS + 1 : SAMPLE_BITS - 1,
    localparam int IO_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IO_W-1:0]      s_tdata,    // left_sample, right_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [IO_W-1:0]      m_tdata,    // left_out, right_out
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    salsl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    salsl_dpath
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .CFG_W       (CFG_W),
        .IO_W        (IO_W)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transaction");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.op == OP_EMIT))
        else $error("output valid rose without an emit step");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) && status.out_stall |=> (cmd.op == OP_EMIT))
        else $error("emit step left while output stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/slew_limiter_checker.sv =====
`timescale 1ns / 100ps

module slew_limiter_checker
    import salsl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [24:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int     COEF_BITS  = 24;
    localparam int     ALIGN_UP   = STATE_FRAC - 23;
    localparam longint ROUND_HALF = longint'(1) << (COEF_BITS - 1);
    localparam longint STATE_MAX  = 64'sd2147483647;
    localparam longint STATE_MIN  = -64'sd2147483648;
    localparam longint SAMPLE_MAX = 64'sd8388607;
    localparam longint SAMPLE_MIN = -64'sd8388608;
    localparam logic [24:0] COEF_ONE = 25'h1000000;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
    } stereo_t;

    stereo_t     expected_pairs[$];
    int          lp_bank[12];
    int          prev_out[2];
    logic        first_bank;
    logic [24:0] coef_first;
    logic [24:0] coef_smooth;
    logic [22:0] slew_thr;

    function automatic logic [24:0] clamp_coef(input logic [24:0] c);
        return (c > COEF_ONE) ? COEF_ONE : c;
    endfunction

    // one-pole step, coefficient split in a high and a low part
    function automatic longint lp_stage(input longint y, input longint x, input logic [24:0] c);
        longint d;
        longint t;
        longint v;
        d = x - y;
        t = d * longint'(c[24:16]);
        v = d * longint'(c[15:0]) + ROUND_HALF;
        return y + ((t + (v >>> 16)) >>> (COEF_BITS - 16));
    endfunction

    function automatic logic [23:0] filter_channel(input int ch, input logic [23:0] raw,
                                                   input int sel);
        longint dry;
        longint x;
        longint a;
        longint b;
        longint e;
        longint hp;
        longint thr;
        longint r;
        int     base;
        base = ch * 6 + sel;
        dry  = longint'($signed(raw)) <<< ALIGN_UP;
        x    = (dry + longint'(prev_out[ch])) >>> 1;
        a    = lp_stage(longint'(lp_bank[base]), x, clamp_coef(coef_first));
        lp_bank[base] = int'(a);
        b    = lp_stage(longint'(lp_bank[base + 2]), a, clamp_coef(coef_smooth));
        lp_bank[base + 2] = int'(b);
        e    = lp_stage(longint'(lp_bank[base + 4]), b, clamp_coef(coef_smooth));
        lp_bank[base + 4] = int'(e);
        thr  = longint'(slew_thr) <<< ALIGN_UP;
        hp   = dry - e;
        if (hp - a > thr)
        begin
            hp = a + thr;
        end
        if (hp - a < -thr)
        begin
            hp = a - thr;
        end
        if (hp > STATE_MAX)
        begin
            hp = STATE_MAX;
        end
        else if (hp < STATE_MIN)
        begin
            hp = STATE_MIN;
        end
        prev_out[ch] = int'(hp);
        r = (hp + (longint'(1) <<< (ALIGN_UP - 1))) >>> ALIGN_UP;
        if (r > SAMPLE_MAX)
        begin
            r = SAMPLE_MAX;
        end
        else if (r < SAMPLE_MIN)
        begin
            r = SAMPLE_MIN;
        end
        return r[23:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        stereo_t want;
        int      sel;
        if (!rst_n)
        begin
            foreach (lp_bank[i])
            begin
                lp_bank[i] = 0;
            end
            prev_out[0] = 0;
            prev_out[1] = 0;
            first_bank  = 1'b1;
            coef_first  = 25'(RST_FIRST_COEF);
            coef_smooth = 25'(RST_SMOOTH_COEF);
            slew_thr    = 23'(RST_SLEW_THR);
            expected_pairs.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FIRST_COEF:  coef_first = cfg_data;
                    REG_SMOOTH_COEF: coef_smooth = cfg_data;
                    REG_SLEW_THR:    slew_thr = cfg_data[22:0];
                    default:         ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("unexpected output transaction: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (m_tdata[23:0] !== want.left)
                    begin
                        $error("left_out: expected %0d, actual %0d",
                               $signed(want.left), $signed(m_tdata[23:0]));
                        fail_count++;
                    end
                    if (m_tdata[47:24] !== want.right)
                    begin
                        $error("right_out: expected %0d, actual %0d",
                               $signed(want.right), $signed(m_tdata[47:24]));
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                sel = first_bank ? 0 : 1;
                want.left  = filter_channel(0, s_tdata[23:0], sel);
                want.right = filter_channel(1, s_tdata[47:24], sel);
                expected_pairs.push_back(want);
                first_bank = ~first_bank;
            end
            pending = expected_pairs.size();
        end
    end

endmodule

// ===== tb/stereo_alternating_lowpass_slew_limiter_top_tb.sv =====
`timescale 1ns / 100ps

module stereo_alternating_lowpass_slew_limiter_top_tb
    import salsl_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_PAIRS    = 108;
    localparam int QUIET_PHASE    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [24:0] COEF_ONE = 25'h1000000;
    localparam logic [24:0] CFG_ALL  = 25'h1FFFFFF;
    localparam logic [24:0] THR_MAX  = 25'h07FFFFF;

    localparam logic [23:0] POS_FULL = 24'h7FFFFF;
    localparam logic [23:0] NEG_FULL = 24'h800000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [47:0]          s_tdata = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_COEF;
    logic [24:0]          cfg_data = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [47:0]          m_tdata;
    wire                  cfg_ready;

    logic        stall_en = 1'b1;
    logic [47:0] pair_q[$];
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;

    stereo_alternating_lowpass_slew_limiter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slew_limiter_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sample pair source, holds each transaction until accepted
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (pair_q.size() != 0 && !(stall_en && $urandom_range(0, 99) < 23))
            begin
                s_tdata  <= pair_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= !(stall_en && $urandom_range(0, 99) < 23);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_pair(input logic [23:0] left, input logic [23:0] right);
        pair_q.push_back({right, left});
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pair_q.size() != 0 || s_tvalid || pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [24:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_regs(input logic [24:0] first, input logic [24:0] smooth,
                                input logic [24:0] thr);
        wait_idle();
        @(posedge clk);
        write_reg(REG_UNUSED, 25'($urandom));
        write_reg(REG_FIRST_COEF, first);
        write_reg(REG_SMOOTH_COEF, smooth);
        write_reg(REG_SLEW_THR, thr);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [24:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return CFG_ALL;
            3:       return 25'($urandom_range(0, 200000));
            default: return 25'($urandom);
        endcase
    endfunction

    function automatic logic [24:0] rand_thr();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return THR_MAX;
            2:       return CFG_ALL;
            default: return 25'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_sample(input int mode);
        int   v;
        logic s;
        v = $urandom_range(0, 4000) - 2000;
        s = 1'($urandom);
        case (mode)
            0: return 24'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return POS_FULL;
                    1:       return NEG_FULL;
                    2:       return 24'h000000;
                    3:       return 24'hFFFFFF;
                    default: return 24'h000001;
                endcase
            end
            2: return v[23:0];
            default: return {s, ~s, 22'($urandom)};
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_pair(24'h000000, 24'h000000);
        push_pair(POS_FULL, NEG_FULL);
        push_pair(NEG_FULL, POS_FULL);
        push_pair(POS_FULL, POS_FULL);
        push_pair(NEG_FULL, NEG_FULL);
        push_pair(24'h000001, 24'hFFFFFF);

        // coefficients of exactly one, widest threshold
        program_regs(COEF_ONE, COEF_ONE, THR_MAX);
        push_pair(POS_FULL, NEG_FULL);
        push_pair(NEG_FULL, POS_FULL);
        push_pair(POS_FULL, NEG_FULL);
        push_pair(NEG_FULL, POS_FULL);

        // coefficients above one, threshold with bits beyond its width
        program_regs(CFG_ALL, CFG_ALL, CFG_ALL);
        push_pair(POS_FULL, POS_FULL);
        push_pair(NEG_FULL, NEG_FULL);
        push_pair(POS_FULL, NEG_FULL);
        push_pair(24'h000000, 24'h000000);

        program_regs('0, '0, '0);
        push_pair(POS_FULL, NEG_FULL);
        push_pair(NEG_FULL, POS_FULL);
        push_pair(24'h123456, 24'hABCDEF);
        push_pair(24'h000000, 24'hFFFFFF);

        program_regs(COEF_ONE, COEF_ONE + 25'd1, 25'd1);
        push_pair(POS_FULL, NEG_FULL);
        push_pair(NEG_FULL, POS_FULL);
        push_pair(POS_FULL, POS_FULL);
        push_pair(NEG_FULL, NEG_FULL);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                program_regs(25'(RST_FIRST_COEF), 25'(RST_SMOOTH_COEF), 25'(RST_SLEW_THR));
            end
            else
            begin
                program_regs(rand_coef(), rand_coef(), rand_thr());
            end
            stall_en <= (ph != QUIET_PHASE);
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                push_pair(pick_sample(ph % 4), pick_sample((ph + n) % 4));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== stereo_alternating_lowpass_slew_limiter_top.f =====
src/salsl_pkg.sv
src/salsl_ctrl.sv
src/salsl_dpath.sv
src/stereo_alternating_lowpass_slew_limiter_top.sv
tb/slew_limiter_checker.sv
tb/stereo_alternating_lowpass_slew_limiter_top_tb.sv
